// ----- rtl/core/cigar_clip_to_reference_unit_defines.svh -----
// ---------------------------------------------------------------------------
// cigar clip assertion macros
// shared concurrent assertion wrappers, clocked on clk and gated by rst_n
// ---------------------------------------------------------------------------
`ifndef CIGAR_CLIP_TO_REFERENCE_UNIT_DEFINES_SVH
`define CIGAR_CLIP_TO_REFERENCE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CCTR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CCTR_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CCTR_ASSERT(lbl, prop, msg)
`define CCTR_NEVER(lbl, expr, msg)
`endif
`endif

// ----- rtl/core/cctr_pkg.sv -----
// ---------------------------------------------------------------------------
// cctr_pkg
// types, operation codes and helpers for the cigar reference clipper
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cctr_pkg;

    localparam int MAX_OPS_DEFAULT = 32;
    localparam int POS_W = 31;
    localparam int LEN_W = 28;
    localparam int TYPE_W = 4;

    localparam logic [TYPE_W-1:0] OP_M   = 4'd0;
    localparam logic [TYPE_W-1:0] OP_I   = 4'd1;
    localparam logic [TYPE_W-1:0] OP_D   = 4'd2;
    localparam logic [TYPE_W-1:0] OP_N   = 4'd3;
    localparam logic [TYPE_W-1:0] OP_S   = 4'd4;
    localparam logic [TYPE_W-1:0] OP_H   = 4'd5;
    localparam logic [TYPE_W-1:0] OP_P   = 4'd6;
    localparam logic [TYPE_W-1:0] OP_EQ  = 4'd7;
    localparam logic [TYPE_W-1:0] OP_X   = 4'd8;

    localparam logic OPC_HEADER = 1'b0;
    localparam logic OPC_OP     = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] query_start;
        logic [POS_W-1:0] query_end;
        logic [POS_W-1:0] ref_start;
        logic [POS_W-1:0] ref_end;
        logic [POS_W-1:0] win_start;
        logic [POS_W-1:0] win_end;
        logic             strand;
    } hdr_t;

    typedef struct packed {
        logic              en;
        logic [TYPE_W-1:0] op_type;
        logic [LEN_W-1:0]  op_length;
    } wr_t;

    function automatic logic uses_query(input logic [TYPE_W-1:0] t);
        return (t == OP_M) || (t == OP_I) || (t == OP_S) || (t == OP_EQ) || (t == OP_X);
    endfunction

    function automatic logic uses_ref(input logic [TYPE_W-1:0] t);
        return (t == OP_M) || (t == OP_D) || (t == OP_N) || (t == OP_EQ) || (t == OP_X);
    endfunction

    function automatic logic [POS_W-1:0] max_pos(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [POS_W-1:0] min_pos(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ----- rtl/core/cctr_front.sv -----
// ---------------------------------------------------------------------------
// cctr_front
// takes header and operation requests, keeps the header, hands out records
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cctr_front #(
    parameter int MAX_OPS = cctr_pkg::MAX_OPS_DEFAULT,
    parameter int CNT_W   = $clog2(MAX_OPS + 1),
    parameter int IDX_W   = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [cctr_pkg::POS_W-1:0]  orig_query_start,
    input  logic [cctr_pkg::POS_W-1:0]  orig_query_end,
    input  logic [cctr_pkg::POS_W-1:0]  orig_ref_start,
    input  logic [cctr_pkg::POS_W-1:0]  orig_ref_end,
    input  logic [cctr_pkg::POS_W-1:0]  window_ref_start,
    input  logic [cctr_pkg::POS_W-1:0]  window_ref_end,
    input  logic                        reverse_strand,
    input  logic [cctr_pkg::TYPE_W-1:0] op_type,
    input  logic [cctr_pkg::LEN_W-1:0]  op_length,
    input  logic                        last_item,
    input  logic                        back_idle,
    input  logic                        job_busy,
    output cctr_pkg::wr_t               ld_wr,
    output logic [IDX_W-1:0]            ld_addr,
    output logic                        job_push,
    output cctr_pkg::hdr_t              job_hdr,
    output logic [CNT_W-1:0]            job_cnt
);

    cctr_pkg::hdr_t   hdr_reg, hdr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             store_op;

    assign in_ready = back_idle && !job_busy;
    assign accept   = in_valid && in_ready;
    assign store_op = (opcode == cctr_pkg::OPC_OP) && (cnt_reg < CNT_W'(MAX_OPS));

    always_comb
    begin
        hdr_next = hdr_reg;
        cnt_next = cnt_reg;
        if (opcode == cctr_pkg::OPC_HEADER)
        begin
            hdr_next.query_start = orig_query_start;
            hdr_next.query_end   = orig_query_end;
            hdr_next.ref_start   = orig_ref_start;
            hdr_next.ref_end     = orig_ref_end;
            hdr_next.win_start   = window_ref_start;
            hdr_next.win_end     = window_ref_end;
            hdr_next.strand      = reverse_strand;
            cnt_next             = '0;
        end
        else if (store_op)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign ld_wr.en        = accept && store_op;
    assign ld_wr.op_type   = op_type;
    assign ld_wr.op_length = op_length;
    assign ld_addr         = cnt_reg[IDX_W-1:0];

    assign job_push = accept && last_item;
    assign job_hdr  = hdr_next;
    assign job_cnt  = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            hdr_reg <= hdr_next;
            cnt_reg <= last_item ? '0 : cnt_next;
        end
    end

endmodule

// ----- rtl/core/cctr_job_fifo.sv -----
// ---------------------------------------------------------------------------
// cctr_job_fifo
// two-entry queue of finished records between loader and clipper
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cctr_job_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             valid,
    output logic             busy,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] data_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;

    assign valid    = (fill_reg != 2'd0);
    assign busy     = (fill_reg != 2'd0);
    assign pop_data = data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && (fill_reg != 2'd2))
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push && (fill_reg != 2'd2))
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push && (fill_reg != 2'd2)}
                                 - {1'b0, pop && valid};
        end
    end

endmodule

// ----- rtl/core/cctr_back.sv -----
// ---------------------------------------------------------------------------
// cctr_back
// holds the operation store, walks each record from both ends and emits it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cigar_clip_to_reference_unit_defines.svh"

module cctr_back #(
    parameter int MAX_OPS = cctr_pkg::MAX_OPS_DEFAULT,
    parameter int CNT_W   = $clog2(MAX_OPS + 1),
    parameter int IDX_W   = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,
    input  cctr_pkg::wr_t               ld_wr,
    input  logic [IDX_W-1:0]            ld_addr,
    input  logic                        job_valid,
    input  cctr_pkg::hdr_t              job_hdr,
    input  logic [CNT_W-1:0]            job_cnt,
    output logic                        job_pop,
    output logic                        back_idle,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        result_kind,
    output logic [cctr_pkg::TYPE_W-1:0] out_op_type,
    output logic [cctr_pkg::LEN_W-1:0]  out_op_length,
    output logic [cctr_pkg::POS_W-1:0]  clip_offset,
    output logic [cctr_pkg::POS_W-1:0]  new_query_start,
    output logic [cctr_pkg::POS_W-1:0]  new_query_end,
    output logic [cctr_pkg::POS_W-1:0]  new_ref_start,
    output logic                        last_result
);

    localparam int PW = cctr_pkg::POS_W;
    localparam int LW = cctr_pkg::LEN_W;
    localparam int TW = cctr_pkg::TYPE_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_FRONT_RD = 4'd1;
    localparam logic [3:0] ST_FRONT_EX = 4'd2;
    localparam logic [3:0] ST_BACK_RD = 4'd3;
    localparam logic [3:0] ST_BACK_EX = 4'd4;
    localparam logic [3:0] ST_EXF_RD  = 4'd5;
    localparam logic [3:0] ST_EXF_EX  = 4'd6;
    localparam logic [3:0] ST_EXB_RD  = 4'd7;
    localparam logic [3:0] ST_EXB_EX  = 4'd8;
    localparam logic [3:0] ST_EMIT_RD = 4'd9;
    localparam logic [3:0] ST_EMIT_EX = 4'd10;
    localparam logic [3:0] ST_SUM     = 4'd11;

    logic [TW-1:0] type_mem [MAX_OPS];
    logic [LW-1:0] len_mem  [MAX_OPS];

    logic [3:0]       state_reg, state_next;
    cctr_pkg::hdr_t   hdr_reg, hdr_next;
    logic [CNT_W-1:0] head_reg, head_next, tail_reg, tail_next, tail_m1;
    logic [PW-1:0]    rem_reg, rem_next, rf_reg, rf_next, rb_reg, rb_next;
    logic             excise_reg;
    logic [TW-1:0]    rd_type_reg;
    logic [LW-1:0]    rd_len_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             trim_we;
    logic [IDX_W-1:0] trim_addr;
    logic [LW-1:0]    trim_len;

    logic             out_valid_reg, out_load;
    logic             kind_reg, kind_next;
    logic [TW-1:0]    otype_reg, otype_next;
    logic [LW-1:0]    olen_reg, olen_next;
    logic [PW-1:0]    coff_reg, coff_next, nqs_reg, nqs_next, nqe_reg, nqe_next;
    logic [PW-1:0]    nrs_reg, nrs_next;

    logic [PW-1:0] len31, q_add, front_cnt, back_cnt, job_nstart;
    logic          uq, ur, fits, nonempty, out_free;

    assign cfg_ready = 1'b1;
    assign back_idle = (state_reg == ST_IDLE);
    assign tail_m1   = tail_reg - 1'b1;
    assign len31     = {{(PW-LW){1'b0}}, rd_len_reg};
    assign uq        = cctr_pkg::uses_query(rd_type_reg);
    assign ur        = cctr_pkg::uses_ref(rd_type_reg);
    assign fits      = (len31 <= rem_reg);
    assign q_add     = (ur && !fits) ? rem_reg : len31;
    assign nonempty  = (head_reg < tail_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign front_cnt = hdr_reg.strand ? rb_reg : rf_reg;
    assign back_cnt  = hdr_reg.strand ? rf_reg : rb_reg;
    assign job_nstart = cctr_pkg::max_pos(job_hdr.ref_start, job_hdr.win_start);

    always_comb
    begin
        state_next = state_reg;
        hdr_next   = hdr_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        rem_next   = rem_reg;
        rf_next    = rf_reg;
        rb_next    = rb_reg;
        rd_en      = 1'b0;
        rd_addr    = head_reg[IDX_W-1:0];
        trim_we    = 1'b0;
        trim_addr  = head_reg[IDX_W-1:0];
        trim_len   = rd_len_reg - rem_reg[LW-1:0];
        job_pop    = 1'b0;
        out_load   = 1'b0;
        kind_next  = 1'b0;
        otype_next = rd_type_reg;
        olen_next  = rd_len_reg;
        coff_next  = '0;
        nqs_next   = '0;
        nqe_next   = '0;
        nrs_next   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    hdr_next   = job_hdr;
                    head_next  = '0;
                    tail_next  = job_cnt;
                    rf_next    = '0;
                    rb_next    = '0;
                    rem_next   = job_nstart - job_hdr.ref_start;
                    state_next = ST_FRONT_RD;
                end
            end
            ST_FRONT_RD:
            begin
                if ((rem_reg != '0) && nonempty)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_FRONT_EX;
                end
                else
                begin
                    rem_next   = hdr_reg.ref_end
                               - cctr_pkg::min_pos(hdr_reg.ref_end, hdr_reg.win_end);
                    state_next = ST_BACK_RD;
                end
            end
            ST_FRONT_EX:
            begin
                if (uq)
                begin
                    rf_next = rf_reg + q_add;
                end
                if (!ur || fits)
                begin
                    head_next = head_reg + 1'b1;
                    if (ur)
                    begin
                        rem_next = rem_reg - len31;
                    end
                end
                else
                begin
                    trim_we  = 1'b1;
                    rem_next = '0;
                end
                state_next = ST_FRONT_RD;
            end
            ST_BACK_RD:
            begin
                rd_addr = tail_m1[IDX_W-1:0];
                if ((rem_reg != '0) && nonempty)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_BACK_EX;
                end
                else
                begin
                    state_next = ST_EXF_RD;
                end
            end
            ST_BACK_EX:
            begin
                trim_addr = tail_m1[IDX_W-1:0];
                if (uq)
                begin
                    rb_next = rb_reg + q_add;
                end
                if (!ur || fits)
                begin
                    tail_next = tail_m1;
                    if (ur)
                    begin
                        rem_next = rem_reg - len31;
                    end
                end
                else
                begin
                    trim_we  = 1'b1;
                    rem_next = '0;
                end
                state_next = ST_BACK_RD;
            end
            ST_EXF_RD:
            begin
                if (excise_reg && nonempty)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_EXF_EX;
                end
                else
                begin
                    state_next = ST_EXB_RD;
                end
            end
            ST_EXF_EX:
            begin
                if (rd_type_reg == cctr_pkg::OP_I)
                begin
                    rf_next   = rf_reg + len31;
                    head_next = head_reg + 1'b1;
                end
                state_next = ST_EXB_RD;
            end
            ST_EXB_RD:
            begin
                rd_addr = tail_m1[IDX_W-1:0];
                if (excise_reg && nonempty)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_EXB_EX;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EXB_EX:
            begin
                if (rd_type_reg == cctr_pkg::OP_I)
                begin
                    rb_next   = rb_reg + len31;
                    tail_next = tail_m1;
                end
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                if (nonempty)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_EMIT_EX;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_EMIT_EX:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    head_next  = head_reg + 1'b1;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = 1'b1;
                    otype_next = '0;
                    olen_next  = '0;
                    coff_next  = front_cnt;
                    nqs_next   = hdr_reg.query_start + front_cnt;
                    nqe_next   = hdr_reg.query_end - back_cnt;
                    nrs_next   = cctr_pkg::max_pos(hdr_reg.ref_start, hdr_reg.win_start);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // operation store: loader port or trim write-back, one registered read
    always_ff @(posedge clk)
    begin
        if (ld_wr.en)
        begin
            type_mem[ld_addr] <= ld_wr.op_type;
            len_mem[ld_addr]  <= ld_wr.op_length;
        end
        else if (trim_we)
        begin
            len_mem[trim_addr] <= trim_len;
        end
        if (rd_en)
        begin
            rd_type_reg <= type_mem[rd_addr];
            rd_len_reg  <= len_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
        rem_reg <= rem_next;
        rf_reg  <= rf_next;
        rb_reg  <= rb_next;
        if (out_load)
        begin
            kind_reg  <= kind_next;
            otype_reg <= otype_next;
            olen_reg  <= olen_next;
            coff_reg  <= coff_next;
            nqs_reg   <= nqs_next;
            nqe_reg   <= nqe_next;
            nrs_reg   <= nrs_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            excise_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            if (cfg_valid && cfg_ready)
            begin
                excise_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign out_op_type     = otype_reg;
    assign out_op_length   = olen_reg;
    assign clip_offset     = coff_reg;
    assign new_query_start = nqs_reg;
    assign new_query_end   = nqe_reg;
    assign new_ref_start   = nrs_reg;
    assign last_result     = kind_reg;

    `CCTR_NEVER(a_head_past_tail, (state_reg != ST_IDLE) && (head_reg > tail_reg), "head passed tail")
    `CCTR_NEVER(a_tail_range, tail_reg > CNT_W'(MAX_OPS), "tail beyond store depth")
    `CCTR_NEVER(a_load_while_busy, ld_wr.en && (state_reg != ST_IDLE), "store loaded mid-walk")
    `CCTR_ASSERT(a_sum_ends_walk, (state_reg == ST_SUM) && out_free |=> back_idle, "summary did not end walk")

endmodule

// ----- rtl/core/cigar_clip_to_reference_unit.sv -----
// ---------------------------------------------------------------------------
// cigar_clip_to_reference_unit
// clips one aligned read's cigar to a reference window
// ---------------------------------------------------------------------------
// Items load at one per cycle while in_ready is high: a header, then up to
// MAX_OPS operations. The item with last_item set closes the record and the
// input then holds ready low until the record is finished. The clipper walks
// the stored operations from both ends through one single-port store with a
// registered read, a read state and an examine state per operation examined,
// then emits each survivor through the same pair of states and the summary
// from its own state. A trimmed operation is both examined and emitted, insert
// excision on examines up to two more, and a stalled output holds the emit and
// summary states. The output register lets the walk run while a result waits
// to be taken.
`timescale 1ns / 1ps

module cigar_clip_to_reference_unit #(
    parameter int MAX_OPS = cctr_pkg::MAX_OPS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [cctr_pkg::POS_W-1:0]  orig_query_start,
    input  logic [cctr_pkg::POS_W-1:0]  orig_query_end,
    input  logic [cctr_pkg::POS_W-1:0]  orig_ref_start,
    input  logic [cctr_pkg::POS_W-1:0]  orig_ref_end,
    input  logic [cctr_pkg::POS_W-1:0]  window_ref_start,
    input  logic [cctr_pkg::POS_W-1:0]  window_ref_end,
    input  logic                        reverse_strand,
    input  logic [cctr_pkg::TYPE_W-1:0] op_type,
    input  logic [cctr_pkg::LEN_W-1:0]  op_length,
    input  logic                        last_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        result_kind,
    output logic [cctr_pkg::TYPE_W-1:0] out_op_type,
    output logic [cctr_pkg::LEN_W-1:0]  out_op_length,
    output logic [cctr_pkg::POS_W-1:0]  clip_offset,
    output logic [cctr_pkg::POS_W-1:0]  new_query_start,
    output logic [cctr_pkg::POS_W-1:0]  new_query_end,
    output logic [cctr_pkg::POS_W-1:0]  new_ref_start,
    output logic                        last_result
);

    localparam int CNT_W = $clog2(MAX_OPS + 1);
    localparam int IDX_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int JOB_W = $bits(cctr_pkg::hdr_t) + CNT_W;

    cctr_pkg::wr_t    ld_wr;
    logic [IDX_W-1:0] ld_addr;
    logic             job_push, job_pop, job_valid, job_busy, back_idle;
    cctr_pkg::hdr_t   push_hdr, pop_hdr;
    logic [CNT_W-1:0] push_cnt, pop_cnt;

    cctr_front #(
        .MAX_OPS (MAX_OPS),
        .CNT_W   (CNT_W),
        .IDX_W   (IDX_W)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .orig_query_start (orig_query_start),
        .orig_query_end   (orig_query_end),
        .orig_ref_start   (orig_ref_start),
        .orig_ref_end     (orig_ref_end),
        .window_ref_start (window_ref_start),
        .window_ref_end   (window_ref_end),
        .reverse_strand   (reverse_strand),
        .op_type          (op_type),
        .op_length        (op_length),
        .last_item        (last_item),
        .back_idle        (back_idle),
        .job_busy         (job_busy),
        .ld_wr            (ld_wr),
        .ld_addr          (ld_addr),
        .job_push         (job_push),
        .job_hdr          (push_hdr),
        .job_cnt          (push_cnt)
    );

    cctr_job_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data ({push_hdr, push_cnt}),
        .pop       (job_pop),
        .valid     (job_valid),
        .busy      (job_busy),
        .pop_data  ({pop_hdr, pop_cnt})
    );

    cctr_back #(
        .MAX_OPS (MAX_OPS),
        .CNT_W   (CNT_W),
        .IDX_W   (IDX_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .ld_wr           (ld_wr),
        .ld_addr         (ld_addr),
        .job_valid       (job_valid),
        .job_hdr         (pop_hdr),
        .job_cnt         (pop_cnt),
        .job_pop         (job_pop),
        .back_idle       (back_idle),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_kind     (result_kind),
        .out_op_type     (out_op_type),
        .out_op_length   (out_op_length),
        .clip_offset     (clip_offset),
        .new_query_start (new_query_start),
        .new_query_end   (new_query_end),
        .new_ref_start   (new_ref_start),
        .last_result     (last_result)
    );

endmodule
